@@ src/uart_register_model_rx_fifo_core_assert.svh @@
// ----------------------------------------------------------------------------
// UART register model assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_MODEL_RX_FIFO_CORE_ASSERT_SVH
`define UART_REGISTER_MODEL_RX_FIFO_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define URMRX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urmrx: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define URMRX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urmrx: next-cycle check failed");

`endif

@@ src/urmrx_pkg.sv @@
// ----------------------------------------------------------------------------
// urmrx_pkg
// Shared types and constants of the UART register model with receive queue.
// ----------------------------------------------------------------------------
`default_nettype none

package urmrx_pkg;

  localparam int DATA_W = 8;

  // Beat kinds carried on the slave tuser
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_ARRIVE = 2'd2
  } op_t;

  // Register offsets
  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // Fixed register values and bit positions
  localparam logic [7:0]  LSR_BASE     = 8'h60;
  localparam logic [7:0]  MSR_VALUE    = 8'hb0;
  localparam logic [7:0]  IIR_PENDING  = 8'h04;
  localparam logic [7:0]  IIR_NONE     = 8'h01;
  localparam logic [15:0] DIV_RESET    = 16'h0001;
  localparam int          LCR_DLAB_BIT = 7;
  localparam int          FCR_CLR_BIT  = 1;

  // Commands to the receive queue
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  // Status of the receive queue
  typedef struct packed {
    logic              pending;   // head cell holds a byte
    logic              second;    // a byte stands behind the head
    logic              full;      // last cell holds a byte
    logic [DATA_W-1:0] head;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ src/urmrx_cell.sv @@
// ----------------------------------------------------------------------------
// urmrx_cell
// One byte slot of the receive queue; shifts towards the head on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module urmrx_cell
  import urmrx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fifo_ctrl_t        ctrl,
  input  wire logic              prev_valid,
  input  wire logic              next_valid,
  input  wire logic [DATA_W-1:0] next_data,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   valid,
  output logic [DATA_W-1:0]      data
);

  logic valid_next;
  logic take_push;

  // Take the arriving byte in the first empty slot
  assign take_push = ctrl.push && !valid && prev_valid;

  always_comb begin
    priority if (ctrl.clear) begin
      valid_next = 1'b0;
    end else if (ctrl.pop) begin
      valid_next = next_valid;
    end else if (take_push) begin
      valid_next = 1'b1;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Advance payload from the neighbour or load the new byte
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      data <= next_data;
    end else if (take_push) begin
      data <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/urmrx_chain.sv @@
// ----------------------------------------------------------------------------
// urmrx_chain
// Row of byte cells forming the receive queue, head at cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module urmrx_chain
  import urmrx_pkg::*;
#(
  parameter int CELLS = 15
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fifo_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] push_data,
  output fifo_stat_t             stat
);

  logic [CELLS-1:0] vld;
  logic [DATA_W-1:0] dat [CELLS];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic              pv;
    logic              nv;
    logic [DATA_W-1:0] nd;

    // Link each cell to its neighbours; the head sees a filled slot before it, the tail an empty one
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_inner_prev
      assign pv = vld[i-1];
    end

    if (i == CELLS - 1) begin : g_last
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_inner_next
      assign nv = vld[i+1];
      assign nd = dat[i+1];
    end

    urmrx_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_valid(pv),
      .next_valid(nv),
      .next_data (nd),
      .push_data (push_data),
      .valid     (vld[i]),
      .data      (dat[i])
    );
  end

  // Report queue status from the cells at the head and the tail of the row
  if (CELLS > 1) begin : g_second
    assign stat.second = vld[1];
  end else begin : g_single
    assign stat.second = 1'b0;
  end

  assign stat.pending = vld[0];
  assign stat.full    = vld[CELLS-1];
  assign stat.head    = dat[0];

endmodule

`default_nettype wire

@@ src/uart_register_model_rx_fifo_core.sv @@
// ----------------------------------------------------------------------------
// uart_register_model_rx_fifo_core
// 16550-style byte register file with a receive queue built as a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per operation. s_tuser selects a bus read, a bus
//   write or a received byte; s_tdata carries offset and data byte.
//   Master channel: one result beat per operation with the read data, the
//   transmit byte, the interrupt level and, on m_tuser, the transmit flag.
// A result is registered and appears in the cycle after its beat is accepted.
// Throughput: one beat per cycle while the master side is ready.
// The receive queue holds FIFO_DEPTH-1 bytes in a row of cells; a pop
//   shifts every cell one place towards the head in the same cycle.
// Reset: the queue empties, the divisor latch returns to one and all other
//   registers clear; no result is pending after reset.
// Stall: while a result waits and m_tready is low, s_tready drops and the
//   block holds its state and the waiting result unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_model_rx_fifo_core
  import urmrx_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] reg_offset, [10:3] data_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] read_data, [15:8] tx_byte, [16] irq_level
  output logic [0:0]       m_tuser    // [0] tx_valid
);

  localparam int CELLS = FIFO_DEPTH - 1;

  logic              accept;
  logic [2:0]        offset;
  logic [DATA_W-1:0] din;
  logic              dlab;

  logic [15:0] divisor, divisor_next;
  logic [3:0]  ier, ier_next;
  logic [7:0]  lcr, lcr_next;
  logic [7:0]  mcr, mcr_next;
  logic [7:0]  scr, scr_next;

  logic [7:0]  rd;
  logic        txv;
  logic [7:0]  txb;
  logic        pending_after;
  logic        irq_after;

  logic [7:0]  read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        irq_level;

  fifo_ctrl_t  ctrl;
  fifo_ctrl_t  req;
  fifo_stat_t  stat;

  assign accept = s_tvalid && s_tready;
  assign offset = s_tdata[2:0];
  assign din    = s_tdata[10:3];
  assign dlab   = lcr[LCR_DLAB_BIT];

  // Decode one operation against the current register state
  always_comb begin
    rd           = '0;
    txv          = 1'b0;
    txb          = '0;
    req          = '0;
    divisor_next = divisor;
    ier_next     = ier;
    lcr_next     = lcr;
    mcr_next     = mcr;
    scr_next     = scr;
    unique case (op_t'(s_tuser))
      OP_READ: begin
        unique case (offset)
          REG_RBR: begin
            if (dlab) begin
              rd = divisor[7:0];
            end else if (stat.pending) begin
              rd      = stat.head;
              req.pop = 1'b1;
            end
          end
          REG_IER: rd = dlab ? divisor[15:8] : {4'b0000, ier};
          REG_IIR: rd = (stat.pending && ier[0]) ? IIR_PENDING : IIR_NONE;
          REG_LCR: rd = lcr;
          REG_MCR: rd = mcr;
          REG_LSR: rd = LSR_BASE | {7'b0000000, stat.pending};
          REG_MSR: rd = MSR_VALUE;
          default: rd = scr;
        endcase
      end
      OP_WRITE: begin
        unique case (offset)
          REG_RBR: begin
            if (dlab) begin
              divisor_next[7:0] = din;
            end else begin
              txv = 1'b1;
              txb = din;
            end
          end
          REG_IER: begin
            if (dlab) begin
              divisor_next[15:8] = din;
            end else begin
              ier_next = din[3:0];
            end
          end
          REG_IIR: req.clear = din[FCR_CLR_BIT];
          REG_LCR: lcr_next = din;
          REG_MCR: mcr_next = din;
          REG_SCR: scr_next = din;
          default: ;
        endcase
      end
      OP_ARRIVE: req.push = !stat.full;
      default: ;
    endcase
  end

  // Gate queue commands with the handshake
  assign ctrl = accept ? req : '0;

  // Interrupt level as it stands after this operation
  always_comb begin
    priority if (req.clear) begin
      pending_after = 1'b0;
    end else if (req.push) begin
      pending_after = 1'b1;
    end else if (req.pop) begin
      pending_after = stat.second;
    end else begin
      pending_after = stat.pending;
    end
  end
  assign irq_after = pending_after && ier_next[0];

  urmrx_chain #(
    .CELLS(CELLS)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .push_data(din),
    .stat     (stat)
  );

  // Hold the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIV_RESET;
      ier     <= '0;
      lcr     <= '0;
      mcr     <= '0;
      scr     <= '0;
    end else if (accept) begin
      divisor <= divisor_next;
      ier     <= ier_next;
      lcr     <= lcr_next;
      mcr     <= mcr_next;
      scr     <= scr_next;
    end
  end

  // Output stage: accept a new beat whenever the result slot frees
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= rd;
      tx_valid  <= txv;
      tx_byte   <= txb;
      irq_level <= irq_after;
    end
  end

  assign m_tdata = {7'b0000000, irq_level, tx_byte, read_data};
  assign m_tuser = tx_valid;

endmodule

`default_nettype wire

@@ src/urmrx_checker.sv @@
// ----------------------------------------------------------------------------
// urmrx_checker
// Port-level checks on the UART register model, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_register_model_rx_fifo_core_assert.svh"

module urmrx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // A stalled result beat holds
  `URMRX_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Every accepted operation yields a result beat in the next cycle
  `URMRX_ASSERT_NEXT(a_result, s_tvalid && s_tready, m_tvalid)

  // A transmit beat never carries read data
  `URMRX_ASSERT_NOW(a_tx_rd, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00)

  // Without a transmit the transmit byte is zero
  `URMRX_ASSERT_NOW(a_no_tx, m_tvalid && !m_tuser[0], m_tdata[15:8] == 8'h00)

endmodule

bind uart_register_model_rx_fifo_core urmrx_checker u_urmrx_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
